/* src/met_pkg.sv */
// Shared types, constants and helper functions of the escape-time block.
// Used by the escape-time engine, the checker and the bench; depends on nothing.
`timescale 1ns / 1ps
package met_pkg;

   localparam int FRAC_BITS          = 28;
   localparam int HISTORY_DEPTH      = 512;
   localparam int LOOP_WINDOW_POINTS = 498;

   // Orbit values stay below 16 in magnitude and the cardioid product below 128,
   // so eight integer bits are enough.
   localparam int VAL_W   = FRAC_BITS + 8;
   localparam int PROD_W  = 2 * VAL_W;
   localparam int CNT_W   = 24;
   localparam int HIST_AW = $clog2(HISTORY_DEPTH);
   localparam int WIN_W   = $clog2(LOOP_WINDOW_POINTS + 1);
   localparam int IN_W    = 32;

   localparam logic signed [VAL_W-1:0] ONE_FX       = VAL_W'(1) <<< FRAC_BITS;
   localparam logic signed [VAL_W-1:0] TWO_FX       = VAL_W'(2) <<< FRAC_BITS;
   localparam logic signed [VAL_W-1:0] NEG_TWO_FX   = -TWO_FX;
   localparam logic signed [VAL_W:0]   FOUR_FX      = (VAL_W + 1)'(4) <<< FRAC_BITS;
   localparam logic signed [VAL_W-1:0] QUARTER_FX   = VAL_W'(1) <<< (FRAC_BITS - 2);
   localparam logic signed [VAL_W-1:0] SIXTEENTH_FX = VAL_W'(1) <<< (FRAC_BITS - 4);

   localparam logic [CNT_W-1:0] MAX_ITER_RESET = CNT_W'(10000000);
   localparam logic [CNT_W-1:0] MIN_ITER_RESET = CNT_W'(1000);
   localparam logic [CNT_W-1:0] INTERVAL_RESET = CNT_W'(10000);

   localparam int CSR_AW = 4;

   typedef enum logic [1:0] {
      REG_MAX_ITER = 2'd0,
      REG_MIN_ITER = 2'd1,
      REG_INTERVAL = 2'd2,
      REG_UNUSED   = 2'd3
   } reg_index_type;

   typedef enum logic [1:0] {
      OUT_ESCAPED  = 2'd0,
      OUT_INTERIOR = 2'd1,
      OUT_LIMIT    = 2'd2,
      OUT_LOOP     = 2'd3
   } outcome_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_IN0, ST_IN1, ST_IN2, ST_IN3, ST_IN4, ST_IN5, ST_IN6,
      ST_ITA, ST_ITB, ST_ITC, ST_ITD,
      ST_LOOP,
      ST_DONE
   } state_type;

   function automatic logic [HIST_AW-1:0] slot_dec(input logic [HIST_AW-1:0] slot);
      if (slot == '0) begin
         return HIST_AW'(HISTORY_DEPTH - 1);
      end
      return slot - HIST_AW'(1);
   endfunction

   function automatic logic [HIST_AW-1:0] slot_inc(input logic [HIST_AW-1:0] slot);
      if (slot == HIST_AW'(HISTORY_DEPTH - 1)) begin
         return '0;
      end
      return slot + HIST_AW'(1);
   endfunction

endpackage

/* src/met_ram.sv */
// Generic single-write, single-read synchronous RAM with registered read data.
// Stands alone; no package needed.
`timescale 1ns / 1ps
module met_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* src/mandelbrot_escape_time.sv */
// Escape-time engine: interior test, shared-multiplier iteration and loop search.
// Depends on met_pkg and met_ram.
`timescale 1ns / 1ps
// One point c per input beat, one result beat per point. The engine works on one
// point at a time around a single shared multiplier: the cardioid and bulb test
// steps through ST_IN0 up to ST_IN6, and each orbit iteration through ST_ITA to
// ST_ITD (three products and the update). At every loop-check step the engine
// walks the orbit history memory backward, one stored point per cycle, up to the
// window length, through the memory's single read port; a walk that gives up goes
// back to ST_ITA to redo the escape test. A finished point passes through ST_DONE
// to hand the result to the output register. A new point is taken while the
// previous result still waits in the output register. The history memory needs
// no clearing pass.
module mandelbrot_escape_time (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // [31:0] c_real, [63:32] c_imag
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [23:0] escape_count
   output logic [2:0]  rsp_tuser,    // [1:0] outcome, [2] worth_drawing
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [met_pkg::CSR_AW-1:0] csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int VW = met_pkg::VAL_W;
   localparam int CW = met_pkg::CNT_W;
   localparam int AW = met_pkg::HIST_AW;
   localparam int WW = met_pkg::WIN_W;

   // Configuration registers.
   logic [CW-1:0] max_iter_ff, min_iter_ff, interval_ff;
   logic          csr_write;
   met_pkg::reg_index_type csr_index;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = met_pkg::reg_index_type'(csr_paddr[3:2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff <= met_pkg::MAX_ITER_RESET;
         min_iter_ff <= met_pkg::MIN_ITER_RESET;
         interval_ff <= met_pkg::INTERVAL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            met_pkg::REG_MAX_ITER: max_iter_ff <= csr_pwdata[CW-1:0];
            met_pkg::REG_MIN_ITER: min_iter_ff <= csr_pwdata[CW-1:0];
            met_pkg::REG_INTERVAL: interval_ff <= csr_pwdata[CW-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         met_pkg::REG_MAX_ITER: csr_prdata = 32'(max_iter_ff);
         met_pkg::REG_MIN_ITER: csr_prdata = 32'(min_iter_ff);
         met_pkg::REG_INTERVAL: csr_prdata = 32'(interval_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Engine state.
   met_pkg::state_type state_ff, state_in;
   logic signed [VW-1:0] cr_ff, ci_ff, re_ff, im_ff;
   logic signed [VW-1:0] cr_in, ci_in, re_in, im_in;
   logic signed [VW-1:0] sq_re_ff, sq_im_ff, ci2_ff, q_ff, qx_ff, t1_ff;
   logic signed [VW-1:0] sq_re_in, sq_im_in, ci2_in, q_in, qx_in, t1_in;
   logic signed [met_pkg::PROD_W-1:0] prod_ff;
   logic signed [VW-1:0] mul_a, mul_b;
   logic [CW-1:0] it_ff, it_in, phase_ff, phase_in;
   logic          checked_ff, checked_in;
   logic [AW-1:0] wr_slot_ff, wr_slot_in, rd_slot_ff, rd_slot_in;
   logic [WW-1:0] rem_ff, rem_in;
   logic [CW-1:0] count_ff, count_in;
   met_pkg::outcome_type code_ff, code_in;
   logic          mem_we;
   logic [2*VW-1:0] mem_wdata, mem_rdata;

   logic          rsp_valid_ff;
   logic [CW-1:0] rsp_count_ff;
   met_pkg::outcome_type rsp_code_ff;
   logic          rsp_draw_ff;

   // Shared datapath terms.
   logic signed [met_pkg::PROD_W-1:0] prod_sh;
   logic signed [VW-1:0] prod_s, x_val, b_val, new_re, new_im, hist_re, hist_im;
   logic signed [VW-1:0] req_re, req_im;
   logic signed [VW:0]   esc_sum;
   logic c_far, z_far, escaped_now, card_in, bulb_in, loop_due, out_free;
   logic [CW-1:0] it_less2;
   logic [WW-1:0] walk_len;

   assign req_re  = VW'($signed(req_tdata[31:0]));
   assign req_im  = VW'($signed(req_tdata[63:32]));
   // Arithmetic shift of the exact product rounds toward minus infinity.
   assign prod_sh = prod_ff >>> met_pkg::FRAC_BITS;
   assign prod_s  = prod_sh[VW-1:0];
   assign x_val   = cr_ff - met_pkg::QUARTER_FX;
   assign b_val   = cr_ff + met_pkg::ONE_FX;
   assign c_far   = (req_re >= met_pkg::TWO_FX) || (req_re <= met_pkg::NEG_TWO_FX) ||
                    (req_im >= met_pkg::TWO_FX) || (req_im <= met_pkg::NEG_TWO_FX);
   assign z_far   = (re_ff > met_pkg::TWO_FX) || (re_ff < met_pkg::NEG_TWO_FX) ||
                    (im_ff > met_pkg::TWO_FX) || (im_ff < met_pkg::NEG_TWO_FX);
   assign esc_sum = (VW + 1)'(sq_re_ff) + (VW + 1)'(prod_s);
   assign escaped_now = esc_sum > met_pkg::FOUR_FX;
   assign card_in = t1_ff < prod_s;
   assign bulb_in = (prod_s + ci2_ff) < met_pkg::SIXTEENTH_FX;
   assign loop_due = (it_ff != '0) && (interval_ff != '0) && (phase_ff == '0) &&
                     !checked_ff;
   assign new_re  = sq_re_ff - sq_im_ff + cr_ff;
   assign new_im  = prod_s + ci_ff;
   assign hist_re = mem_rdata[VW-1:0];
   assign hist_im = mem_rdata[2*VW-1:VW];
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign it_less2 = it_ff - CW'(2);
   assign walk_len = (it_less2 >= CW'(met_pkg::LOOP_WINDOW_POINTS)) ?
                     WW'(met_pkg::LOOP_WINDOW_POINTS) : it_less2[WW-1:0];

   assign req_tready = (state_ff == met_pkg::ST_IDLE);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         met_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = c_far ? met_pkg::ST_ITA : met_pkg::ST_IN0;
            end
         end
         met_pkg::ST_IN0: state_in = met_pkg::ST_IN1;
         met_pkg::ST_IN1: state_in = met_pkg::ST_IN2;
         met_pkg::ST_IN2: state_in = met_pkg::ST_IN3;
         met_pkg::ST_IN3: state_in = met_pkg::ST_IN4;
         met_pkg::ST_IN4: state_in = met_pkg::ST_IN5;
         met_pkg::ST_IN5: state_in = card_in ? met_pkg::ST_DONE : met_pkg::ST_IN6;
         met_pkg::ST_IN6: state_in = bulb_in ? met_pkg::ST_DONE : met_pkg::ST_ITA;
         met_pkg::ST_ITA: state_in = z_far ? met_pkg::ST_DONE : met_pkg::ST_ITB;
         met_pkg::ST_ITB: state_in = met_pkg::ST_ITC;
         met_pkg::ST_ITC: begin
            if (escaped_now || it_ff == max_iter_ff) begin
               state_in = met_pkg::ST_DONE;
            end else if (loop_due && it_ff >= CW'(3)) begin
               state_in = met_pkg::ST_LOOP;
            end else begin
               state_in = met_pkg::ST_ITD;
            end
         end
         met_pkg::ST_ITD: state_in = met_pkg::ST_ITA;
         met_pkg::ST_LOOP: begin
            if (hist_re == re_ff) begin
               state_in = (hist_im == im_ff) ? met_pkg::ST_DONE : met_pkg::ST_ITA;
            end else if (rem_ff == WW'(1)) begin
               state_in = met_pkg::ST_ITA;
            end
         end
         met_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = met_pkg::ST_IDLE;
            end
         end
         default: state_in = met_pkg::ST_IDLE;
      endcase
   end

   // Datapath controls and next values.
   always_comb begin
      cr_in = cr_ff;   ci_in = ci_ff;   re_in = re_ff;   im_in = im_ff;
      sq_re_in = sq_re_ff;  sq_im_in = sq_im_ff;  ci2_in = ci2_ff;
      q_in = q_ff;  qx_in = qx_ff;  t1_in = t1_ff;
      it_in = it_ff;  phase_in = phase_ff;  checked_in = checked_ff;
      wr_slot_in = wr_slot_ff;  rd_slot_in = rd_slot_ff;  rem_in = rem_ff;
      count_in = count_ff;  code_in = code_ff;
      mul_a = re_ff;  mul_b = re_ff;
      mem_we = 1'b0;
      mem_wdata = {new_im, new_re};
      unique case (state_ff)
         met_pkg::ST_IDLE: begin
            cr_in = req_re;  ci_in = req_im;
            re_in = '0;  im_in = '0;  it_in = '0;  phase_in = '0;
            checked_in = 1'b0;  wr_slot_in = '0;
         end
         met_pkg::ST_IN0: begin
            mul_a = ci_ff;  mul_b = ci_ff;
         end
         met_pkg::ST_IN1: begin
            ci2_in = prod_s;
            mul_a = x_val;  mul_b = x_val;
         end
         met_pkg::ST_IN2: begin
            q_in  = prod_s + ci2_ff;
            qx_in = prod_s + ci2_ff + x_val;
         end
         met_pkg::ST_IN3: begin
            mul_a = q_ff;  mul_b = qx_ff;
         end
         met_pkg::ST_IN4: begin
            t1_in = prod_s;
            mul_a = met_pkg::QUARTER_FX;  mul_b = ci2_ff;
         end
         met_pkg::ST_IN5: begin
            mul_a = b_val;  mul_b = b_val;
            count_in = max_iter_ff;  code_in = met_pkg::OUT_INTERIOR;
         end
         met_pkg::ST_IN6: begin
            count_in = max_iter_ff;  code_in = met_pkg::OUT_INTERIOR;
         end
         met_pkg::ST_ITA: begin
            count_in = it_ff;  code_in = met_pkg::OUT_ESCAPED;
         end
         met_pkg::ST_ITB: begin
            sq_re_in = prod_s;
            mul_a = im_ff;  mul_b = im_ff;
         end
         met_pkg::ST_ITC: begin
            sq_im_in = prod_s;
            mul_a = re_ff <<< 1;  mul_b = im_ff;
            if (escaped_now) begin
               count_in = it_ff;  code_in = met_pkg::OUT_ESCAPED;
            end else begin
               count_in = max_iter_ff;  code_in = met_pkg::OUT_LIMIT;
            end
            if (loop_due) begin
               // Too few points for any candidate means the search gives up at once.
               checked_in = 1'b1;
               rd_slot_in = met_pkg::slot_dec(met_pkg::slot_dec(wr_slot_ff));
               rem_in = walk_len;
            end
         end
         met_pkg::ST_ITD: begin
            mem_we = 1'b1;
            re_in = new_re;  im_in = new_im;
            it_in = it_ff + CW'(1);
            phase_in = (phase_ff == interval_ff - CW'(1)) ? '0 : phase_ff + CW'(1);
            wr_slot_in = met_pkg::slot_inc(wr_slot_ff);
            checked_in = 1'b0;
         end
         met_pkg::ST_LOOP: begin
            count_in = max_iter_ff;  code_in = met_pkg::OUT_LOOP;
            rd_slot_in = met_pkg::slot_dec(rd_slot_ff);
            rem_in = rem_ff - WW'(1);
         end
         met_pkg::ST_DONE: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= met_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == met_pkg::ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      cr_ff <= cr_in;  ci_ff <= ci_in;  re_ff <= re_in;  im_ff <= im_in;
      sq_re_ff <= sq_re_in;  sq_im_ff <= sq_im_in;  ci2_ff <= ci2_in;
      q_ff <= q_in;  qx_ff <= qx_in;  t1_ff <= t1_in;
      prod_ff <= mul_a * mul_b;
      it_ff <= it_in;  phase_ff <= phase_in;  checked_ff <= checked_in;
      wr_slot_ff <= wr_slot_in;  rd_slot_ff <= rd_slot_in;  rem_ff <= rem_in;
      count_ff <= count_in;  code_ff <= code_in;
      if (state_ff == met_pkg::ST_DONE && out_free) begin
         rsp_count_ff <= count_ff;
         rsp_code_ff  <= code_ff;
         rsp_draw_ff  <= (code_ff == met_pkg::OUT_ESCAPED) &&
                         (count_ff > min_iter_ff) && (count_ff < max_iter_ff);
      end
   end

   // The read address follows the next walk slot, so the data seen in the walk
   // belongs to the slot held in rd_slot_ff.
   met_ram #(
      .WIDTH (2 * VW),
      .DEPTH (met_pkg::HISTORY_DEPTH)
   ) u_history (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (wr_slot_ff),
      .wr_data (mem_wdata),
      .rd_addr (rd_slot_in),
      .rd_data (mem_rdata)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_count_ff;
   assign rsp_tuser  = {rsp_draw_ff, rsp_code_ff};

endmodule

/* src/met_checker.sv */
// Port-level checks of the escape-time block, bound to the top level.
// Depends on met_pkg and mandelbrot_escape_time.
`timescale 1ns / 1ps
module met_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);

   // A result register never survives reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only an escaped point can be worth drawing.
   a_draw_escaped: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == met_pkg::OUT_ESCAPED)
      else $error("worth_drawing set on a non-escaped result");

   // The engine drops ready after taking a point.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input ready right after an accepted point");

endmodule

bind mandelbrot_escape_time met_checker u_met_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/sv/tb.sv */
// Self-checking bench for mandelbrot_escape_time: points go in as stream beats, results
// are predicted by an in-bench fixed-point orbit model. Depends on met_pkg and the block.
`timescale 1ns / 1ps
module tb;

   localparam int WATCHDOG_LIMIT = 400000;
   localparam longint FX_ONE = longint'(1) << met_pkg::FRAC_BITS;

   typedef struct {
      logic [23:0] count;
      met_pkg::outcome_type outcome;
      logic        draw;
   } escape_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic [2:0]  rsp_tuser;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [met_pkg::CSR_AW-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   mandelbrot_escape_time dut (.*);

   always #6 clock = ~clock;

   // Predictor state: its own copy of the registers and of the orbit memory.
   logic [23:0] iter_limit = 24'd10000000;
   logic [23:0] draw_floor = 24'd1000;
   logic [23:0] check_every = 24'd10000;
   longint orbit_re [met_pkg::HISTORY_DEPTH];
   longint orbit_im [met_pkg::HISTORY_DEPTH];

   escape_result_type pending_results[$];
   int errors = 0;
   int idle_cycles = 0;
   bit quiet = 0;
   int stall_left = 0;

   function automatic longint fx_mul(longint a, longint b);
      logic signed [127:0] p;
      p = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
      // Taking the bits above the fraction is a floor shift.
      return p[met_pkg::FRAC_BITS+63:met_pkg::FRAC_BITS];
   endfunction

   function automatic bit in_bulb_or_cardioid(longint cr, longint ci);
      longint x, ci2, q, b;
      if (cr >= 2 * FX_ONE || cr <= -2 * FX_ONE || ci >= 2 * FX_ONE || ci <= -2 * FX_ONE)
         return 0;
      x = cr - (FX_ONE >>> 2);
      ci2 = fx_mul(ci, ci);
      q = fx_mul(x, x) + ci2;
      if (fx_mul(q, q + x) < fx_mul(FX_ONE >>> 2, ci2))
         return 1;
      b = cr + FX_ONE;
      return (fx_mul(b, b) + ci2) < (FX_ONE >>> 4);
   endfunction

   function automatic bit orbit_repeats(int n);
      longint nre, nim;
      int k, cnt;
      nre = orbit_re[(n - 1) % met_pkg::HISTORY_DEPTH];
      nim = orbit_im[(n - 1) % met_pkg::HISTORY_DEPTH];
      k = n - 2;
      cnt = 0;
      while (k >= 1 && cnt < met_pkg::LOOP_WINDOW_POINTS) begin
         if (orbit_re[k % met_pkg::HISTORY_DEPTH] == nre)
            return orbit_im[k % met_pkg::HISTORY_DEPTH] == nim;
         k--;
         cnt++;
      end
      return 0;
   endfunction

   function automatic escape_result_type escape_time(logic [31:0] pr, logic [31:0] pi);
      escape_result_type r;
      longint cr, ci, re, im, nre, nim;
      int it;
      cr = longint'($signed(pr));
      ci = longint'($signed(pi));
      re = 0;
      im = 0;
      it = 0;
      r.draw = 0;
      if (in_bulb_or_cardioid(cr, ci)) begin
         r.count = iter_limit;
         r.outcome = met_pkg::OUT_INTERIOR;
         return r;
      end
      forever begin
         if (re > 2 * FX_ONE || re < -2 * FX_ONE || im > 2 * FX_ONE || im < -2 * FX_ONE ||
             fx_mul(re, re) + fx_mul(im, im) > 4 * FX_ONE) begin
            r.count = 24'(it);
            r.outcome = met_pkg::OUT_ESCAPED;
            r.draw = (r.count > draw_floor) && (r.count < iter_limit);
            return r;
         end
         if (it == iter_limit) begin
            r.count = iter_limit;
            r.outcome = met_pkg::OUT_LIMIT;
            return r;
         end
         if (it != 0 && check_every != 0 && it % check_every == 0 && orbit_repeats(it)) begin
            r.count = iter_limit;
            r.outcome = met_pkg::OUT_LOOP;
            return r;
         end
         nre = fx_mul(re, re) - fx_mul(im, im) + cr;
         nim = fx_mul(re * 2, im) + ci;
         re = nre;
         im = nim;
         orbit_re[it % met_pkg::HISTORY_DEPTH] = re;
         orbit_im[it % met_pkg::HISTORY_DEPTH] = im;
         it++;
      end
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   task automatic send_point(logic [31:0] pr, logic [31:0] pi);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {pi, pr};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      pending_results.push_back(escape_time(pr, pi));
   endtask

   // Registers change only once the block has drained.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(met_pkg::reg_index_type idx, logic [23:0] val);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      // Upper byte is random to show it is ignored.
      csr_pwdata <= {8'($urandom), val};
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         met_pkg::REG_MAX_ITER: iter_limit = val;
         met_pkg::REG_MIN_ITER: draw_floor = val;
         met_pkg::REG_INTERVAL: check_every = val;
         default: ;
      endcase
   endtask

   task automatic set_config(logic [23:0] mx, logic [23:0] mn, logic [23:0] iv);
      drain();
      write_reg(met_pkg::REG_MAX_ITER, mx);
      write_reg(met_pkg::REG_MIN_ITER, mn);
      write_reg(met_pkg::REG_INTERVAL, iv);
   endtask

   function automatic logic [31:0] fx(real v);
      return 32'($rtoi(v * 268435456.0));
   endfunction

   task automatic test_reset_values();
      // Only quick points under the reset limit of ten million.
      send_point(fx(0.0), fx(0.0));
      send_point(fx(-1.0), fx(0.0));
      send_point(fx(1.0), fx(1.0));
      send_point(fx(0.5), fx(0.5));
   endtask

   task automatic test_field_extremes();
      set_config(24'hFFFFFF, 24'd0, 24'd1);
      send_point(32'h7FFFFFFF, 32'h7FFFFFFF);
      send_point(32'h80000000, 32'h80000000);
      send_point(32'h7FFFFFFF, 32'h80000000);
      send_point(32'h80000000, 32'h00000000);
      send_point(32'h00000000, 32'h7FFFFFFF);
      send_point(fx(0.1), fx(0.1));
      send_point(fx(-2.0), fx(1.9));
      send_point(fx(2.0), fx(0.0));
   endtask

   task automatic test_zero_limit();
      set_config(24'd0, 24'hFFFFFF, 24'd0);
      send_point(fx(0.0), fx(0.0));
      send_point(fx(1.5), fx(-1.5));
      send_point(fx(-0.75), fx(0.5));
   endtask

   task automatic test_loops_and_limit();
      escape_result_type probe;
      set_config(24'd100, 24'd2, 24'd1);
      send_point(fx(-1.3), fx(0.0));
      send_point(fx(-0.12), fx(0.74));
      send_point(fx(-1.755), fx(0.0));
      set_config(24'd400, 24'd0, 24'd0);
      send_point(fx(-0.12), fx(0.74));
      send_point(fx(-2.0), fx(0.0));
      // Find a slow escape count, then make it the limit so the escape lands on it.
      probe = escape_time(fx(0.26), fx(0.0));
      set_config(probe.count, probe.count - 24'd1, 24'd7);
      send_point(fx(0.26), fx(0.0));
      send_point(fx(0.3), fx(0.0));
   endtask

   task automatic test_random_points();
      logic [23:0] mx, iv;
      logic [31:0] pr, pi;
      for (int phase = 0; phase < 4; phase++) begin
         mx = 24'($urandom_range(1, 300));
         iv = (phase == 3) ? 24'($urandom_range(1, 4)) : 24'($urandom_range(8, 300));
         if (phase == 3)
            mx = 24'($urandom_range(1, 40));
         quiet = (phase == 1);
         set_config(mx, 24'($urandom_range(0, mx)), iv);
         for (int i = 0; i < 20; i++) begin
            if ($urandom_range(0, 9) < 7) begin
               pr = 32'($urandom_range(0, 671088640)) - 32'd536870912;
               pi = 32'($urandom_range(0, 671088640)) - 32'd335544320;
            end else begin
               pr = $urandom();
               pi = $urandom();
            end
            send_point(pr, pi);
         end
      end
      quiet = 0;
   endtask

   always @(posedge clock) begin
      escape_result_type want;
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cycles = 0;
      else if (!reset)
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, actual %h/%h", $time, rsp_tdata, rsp_tuser);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata !== want.count) begin
               $display("%0t: escape_count expected %0d actual %0d", $time, want.count, rsp_tdata);
               errors++;
            end
            if (rsp_tuser[1:0] !== want.outcome) begin
               $display("%0t: outcome expected %0d actual %0d", $time, want.outcome,
                        rsp_tuser[1:0]);
               errors++;
            end
            if (rsp_tuser[2] !== want.draw) begin
               $display("%0t: worth_drawing expected %0d actual %0d", $time, want.draw,
                        rsp_tuser[2]);
               errors++;
            end
         end
      end
      if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         stall_left = gap_len();
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_values();
      test_field_extremes();
      test_zero_limit();
      test_loops_and_limit();
      test_random_points();
      drain();
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
